// File: hw/rtl/rks_pkg.sv
// ----------------------------------------------------------------------------
// rks_pkg: shared types and constants of the RGB keyframe track sampler
// Word formats of both channels, command and status codes, arithmetic widths.
// ----------------------------------------------------------------------------
package rks_pkg;

  localparam int MaxKeysDef = 'h40;
  localparam int KeyCountW  = 7;
  localparam int TimeW      = 16;
  localparam int ValueW     = 16;
  localparam int NumChan    = 3;
  localparam int KeyWordW   = TimeW + NumChan * ValueW;
  localparam int DivNumW    = 34;
  localparam int DivDenW    = 17;

  localparam logic CmdWrite  = 1'b0;
  localparam logic CmdSample = 1'b1;

  localparam logic [1:0] StatInterp   = 2'd0;
  localparam logic [1:0] StatHeld     = 2'd1;
  localparam logic [1:0] StatZeroSpan = 2'd2;
  localparam logic [1:0] StatSat      = 2'd3;

  typedef struct packed {
    logic                     command;
    logic [5:0]               key_index;
    logic [TimeW-1:0]         key_time;
    logic signed [ValueW-1:0] key_value_a;
    logic signed [ValueW-1:0] key_value_b;
    logic signed [ValueW-1:0] key_value_c;
    logic [TimeW-1:0]         sample_time;
  } in_word_t;

  typedef struct packed {
    logic [TimeW-1:0]         echo_time;
    logic signed [ValueW-1:0] out_a;
    logic signed [ValueW-1:0] out_b;
    logic signed [ValueW-1:0] out_c;
    logic [1:0]               status;
  } out_word_t;

endpackage

// File: hw/rtl/rks_div.sv
// ----------------------------------------------------------------------------
// rks_div: serial restoring divider
// Unsigned quotient of num_i by den_i, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module rks_div
  import rks_pkg::*;
#(
  parameter int NUM_W = DivNumW,
  parameter int DEN_W = DivDenW
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [NUM_W-1:0] num_i,
  input  logic [DEN_W-1:0] den_i,
  output logic             done_o,
  output logic [NUM_W-1:0] quot_o
);

  localparam int CntW = $clog2(NUM_W);

  logic             busy_q, done_q;
  logic [CntW-1:0]  cnt_q;
  logic [DEN_W-1:0] rem_q, den_q;
  logic [NUM_W-1:0] quot_q;
  logic [DEN_W:0]   shifted;
  logic             fits;

  assign shifted = {rem_q, quot_q[NUM_W-1]};
  assign fits    = shifted >= {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + CntW'(1);
        if (cnt_q == CntW'(NUM_W - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q  <= '0;
      den_q  <= den_i;
      quot_q <= num_i;
    end else if (busy_q) begin
      rem_q  <= fits ? DEN_W'(shifted - {1'b0, den_q}) : shifted[DEN_W-1:0];
      quot_q <= {quot_q[NUM_W-2:0], fits};
    end
  end

  assign done_o = done_q;
  assign quot_o = quot_q;

endmodule

// File: hw/rtl/rgb_keyframe_track_sampler.sv
// ----------------------------------------------------------------------------
// rgb_keyframe_track_sampler: piecewise linear RGB keyframe track
// Keyframe table with binary search and rounded linear interpolation.
// ----------------------------------------------------------------------------
// A write word stores one key. A sample word runs the binary search and the key
// fetch through the single read port of the key memory, then, when it
// interpolates, each channel in turn uses the one multiplier and the 34-step
// serial divider. Held and zero-span samples skip the channel loop. The input
// is stalled while a sample is in flight; a finished result waits in the
// output register while the next word is taken.
module rgb_keyframe_track_sampler
  import rks_pkg::*;
#(
  parameter int MAX_KEYS = MaxKeysDef
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [KeyCountW-1:0] cfg_data_i,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  in_word_t             in_word_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output out_word_t            out_word_o
);

  localparam int IW = $clog2(MAX_KEYS);

  typedef enum logic [3:0] {
    S_IDLE, S_PROBE, S_CMP, S_KEY0, S_KEY1, S_MUL, S_DIVGO, S_DIV, S_ACC, S_OUT
  } state_e;

  state_e    state_q;
  logic      out_valid_q;
  out_word_t out_word_q;
  logic [KeyCountW-1:0] key_count_q;

  logic [KeyWordW-1:0] mem_q [MAX_KEYS];
  logic [KeyWordW-1:0] rdata_q;
  logic [IW-1:0]       raddr;
  logic                mem_we;

  logic [TimeW-1:0]         t_q, t0_q;
  logic [IW-1:0]            last_q, lo_q, hi_q, mid_q, mid, last_d;
  logic [IW:0]              mid_sum;
  logic signed [ValueW-1:0] y0_q [NumChan];
  logic signed [ValueW:0]   dy_q [NumChan];
  logic signed [TimeW:0]    dt_q, span_q, span_d;
  logic signed [DivNumW-1:0] num_q;
  logic [1:0]               ch_q;
  logic                     neg_q;
  logic signed [ValueW-1:0] res_q [NumChan];
  logic [1:0]               stat_q;

  logic                 in_acc, out_free, div_start, div_done;
  logic [DivNumW-1:0]   num_abs, div_num, div_quot;
  logic [TimeW-1:0]     span_abs;
  logic [DivDenW-1:0]   div_den;
  logic signed [35:0]   acc_v, q_signed;
  logic signed [ValueW-1:0] acc_sat;
  logic                 acc_clip;

  assign in_acc      = in_valid_i && !in_stall_o;
  assign in_stall_o  = (state_q != S_IDLE);
  assign cfg_ready_o = 1'b1;
  assign out_free    = !out_valid_q || !out_stall_i;
  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_count_q <= KeyCountW'(1);
    end else if (cfg_valid_i && cfg_ready_o) begin
      key_count_q <= cfg_data_i;
    end
  end

  // key memory
  assign mem_we = in_acc && (in_word_i.command == CmdWrite)
                  && (32'(in_word_i.key_index) < MAX_KEYS);

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[IW'(in_word_i.key_index)] <= {in_word_i.key_time, in_word_i.key_value_a,
                                          in_word_i.key_value_b, in_word_i.key_value_c};
    end
    rdata_q <= mem_q[raddr];
  end

  assign mid_sum = {1'b0, lo_q} + {1'b0, hi_q} + (IW+1)'(1);
  assign mid     = mid_sum[IW:1];

  always_comb begin
    unique case (state_q)
      S_PROBE: raddr = (lo_q < hi_q) ? mid : lo_q;
      S_KEY0:  raddr = lo_q + IW'(1);
      default: raddr = lo_q;
    endcase
  end

  always_comb begin
    if (key_count_q == '0) begin
      last_d = '0;
    end else if (32'(key_count_q) > MAX_KEYS) begin
      last_d = IW'(MAX_KEYS - 1);
    end else begin
      last_d = IW'(key_count_q - KeyCountW'(1));
    end
  end

  assign span_d   = $signed({1'b0, rdata_q[KeyWordW-1 -: TimeW]}) - $signed({1'b0, t0_q});
  assign span_abs = span_q[TimeW] ? TimeW'(-span_q) : span_q[TimeW-1:0];
  assign num_abs  = num_q[DivNumW-1] ? DivNumW'(-num_q) : DivNumW'(num_q);
  assign div_num  = (num_abs << 1) + DivNumW'(span_abs);
  assign div_den  = {span_abs, 1'b0};
  assign div_start = (state_q == S_DIVGO);

  assign q_signed = $signed({2'b00, div_quot});
  assign acc_v    = 36'(y0_q[ch_q]) + (neg_q ? -q_signed : q_signed);

  always_comb begin
    acc_clip = 1'b1;
    if (acc_v > 36'sd32767) begin
      acc_sat = 16'sh7FFF;
    end else if (acc_v < -36'sd32768) begin
      acc_sat = 16'sh8000;
    end else begin
      acc_sat  = acc_v[ValueW-1:0];
      acc_clip = 1'b0;
    end
  end

  rks_div #(
    .NUM_W(DivNumW),
    .DEN_W(DivDenW)
  ) u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(div_start),
    .num_i  (div_num),
    .den_i  (div_den),
    .done_o (div_done),
    .quot_o (div_quot)
  );

  // sequencer, result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
      out_word_q  <= '0;
    end else begin
      if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE:  if (in_acc && in_word_i.command == CmdSample) state_q <= S_PROBE;
        S_PROBE: state_q <= (lo_q < hi_q) ? S_CMP : S_KEY0;
        S_CMP:   state_q <= S_PROBE;
        S_KEY0:  state_q <= S_KEY1;
        S_KEY1: begin
          if (lo_q >= last_q || span_d == '0) begin
            state_q <= S_OUT;
          end else begin
            state_q <= S_MUL;
          end
        end
        S_MUL:   state_q <= S_DIVGO;
        S_DIVGO: state_q <= S_DIV;
        S_DIV:   if (div_done) state_q <= S_ACC;
        S_ACC:   state_q <= (ch_q == 2'd2) ? S_OUT : S_MUL;
        S_OUT: begin
          if (out_free) begin
            out_valid_q <= 1'b1;
            out_word_q  <= '{echo_time: t_q, out_a: res_q[0], out_b: res_q[1],
                             out_c: res_q[2], status: stat_q};
            state_q     <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      S_IDLE: begin
        t_q    <= in_word_i.sample_time;
        last_q <= last_d;
        lo_q   <= '0;
        hi_q   <= last_d;
      end
      S_PROBE: mid_q <= mid;
      S_CMP: begin
        if (t_q < rdata_q[KeyWordW-1 -: TimeW]) begin
          hi_q <= mid_q - IW'(1);
        end else begin
          lo_q <= mid_q;
        end
      end
      S_KEY0: begin
        t0_q <= rdata_q[KeyWordW-1 -: TimeW];
        for (int k = 0; k < NumChan; k++) begin
          y0_q[k]  <= rdata_q[(NumChan-k)*ValueW-1 -: ValueW];
          res_q[k] <= rdata_q[(NumChan-k)*ValueW-1 -: ValueW];
        end
      end
      S_KEY1: begin
        span_q <= span_d;
        dt_q   <= $signed({1'b0, t_q}) - $signed({1'b0, t0_q});
        ch_q   <= '0;
        for (int k = 0; k < NumChan; k++) begin
          dy_q[k] <= $signed(rdata_q[(NumChan-k)*ValueW-1 -: ValueW]) - y0_q[k];
        end
        if (lo_q >= last_q) begin
          stat_q <= StatHeld;
        end else if (span_d == '0) begin
          stat_q <= StatZeroSpan;
        end else begin
          stat_q <= StatInterp;
        end
      end
      S_MUL:   num_q <= dt_q * dy_q[ch_q];
      S_DIVGO: neg_q <= num_q[DivNumW-1] ^ span_q[TimeW];
      S_ACC: begin
        res_q[ch_q] <= acc_sat;
        ch_q        <= ch_q + 2'd1;
        if (acc_clip) begin
          stat_q <= StatSat;
        end
      end
      default: ;
    endcase
  end

  a_probe_in_bounds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_CMP |-> (mid_q > lo_q) && (mid_q <= hi_q))
    else $error("search probe outside window");

  a_lo_in_table: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_KEY1 |-> lo_q <= last_q)
    else $error("search result beyond last key");

  a_div_done_waited: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> state_q == S_DIV)
    else $error("divider finished outside wait state");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_OUT && out_valid_q && out_stall_i) |=> state_q == S_OUT && out_valid_q)
    else $error("result register overwritten");

  a_one_word_per_sample: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE && $past(state_q) == S_OUT) |-> out_valid_q)
    else $error("sample finished without result");

endmodule
